// File: hw/rtl/rhtn_pkg.sv
// Shared types, constants and helpers for the rectangle hit-test block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rhtn_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 16;

    // Fixed field widths of the stream beats
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int IN_COORD_W = 16;
    localparam int SIZE_W    = 15;
    localparam int DIST_W    = 17;
    localparam int CFG_W     = 5;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    // Derived widths
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int N_W   = $clog2(MAX_RECTS + 1);
    localparam int EXT_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONTAIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRICT  = 2'd2;

    // Internal operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_NOP     = 2'd0;
    localparam t_op OP_WRITE   = 2'd1;
    localparam t_op OP_CONTAIN = 2'd2;
    localparam t_op OP_STRICT  = 2'd3;

    typedef struct packed {
        t_op                   op;
        logic [SLOT_W-1:0]     slot;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [SIZE_W-1:0]     width;
        logic [SIZE_W-1:0]     height;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } t_cmd;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [SIZE_W-1:0]     width;
        logic [SIZE_W-1:0]     height;
    } t_rect;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
        logic              contained;
        logic [DIST_W-1:0] cheb_dist;
    } t_res;

    function automatic logic signed [EXT_W-1:0] sext_coord(input logic [COORD_BITS-1:0] v);
        sext_coord = {{(EXT_W - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [EXT_W-1:0] zext_size(input logic [SIZE_W-1:0] v);
        zext_size = {{(EXT_W - SIZE_W){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rhtn_front.sv
// Front end: accepts input beats, decodes the kind into an operation and
// holds commands in a two-entry queue for the back end. Uses rhtn_pkg.
`default_nettype none

module rhtn_front
    import rhtn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_valid,
    output logic                      o_s_ready,
    input  wire logic [KIND_W-1:0]    i_s_kind,
    input  wire logic [IN_DATA_W-1:0] i_s_data,
    output logic                      o_q_valid,
    output t_cmd                      o_q_cmd,
    input  wire logic                 i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;
    t_cmd       dec;
    logic       push;

    always_comb begin
        unique case (i_s_kind)
            KIND_WRITE:   dec.op = OP_WRITE;
            KIND_CONTAIN: dec.op = OP_CONTAIN;
            KIND_STRICT:  dec.op = OP_STRICT;
            default:      dec.op = OP_NOP;
        endcase
        dec.slot   = i_s_data[3:0];
        dec.left   = i_s_data[4 +: COORD_BITS];
        dec.top    = i_s_data[20 +: COORD_BITS];
        dec.width  = i_s_data[50:36];
        dec.height = i_s_data[65:51];
        dec.px     = i_s_data[66 +: COORD_BITS];
        dec.py     = i_s_data[82 +: COORD_BITS];
    end

    assign o_s_ready = (r_count != 2'd2);
    assign push      = i_s_valid && o_s_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_q[r_rd];

    always_comb begin
        n_count = r_count + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue fill count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_q_valid |-> !i_q_pop)
        else $error("back end popped an empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/rhtn_back.sv
// Back end: rectangle store, count register, containment and nearest
// scans over the store, and the result output register. Uses rhtn_pkg.
`default_nettype none

module rhtn_back
    import rhtn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_q_valid,
    input  wire t_cmd             i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_res_valid,
    output t_res                  o_res,
    input  wire logic             i_res_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_NEAR = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic signed [EXT_W-1:0] ONE_E = 1;

    t_rect             r_store [MAX_RECTS];
    logic [CFG_W-1:0]  r_rect_count;
    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [N_W-1:0]    r_n;
    logic              r_first, n_first;
    logic signed [EXT_W-1:0] r_best, n_best;
    logic [IDX_W-1:0]  r_bidx, n_bidx;
    t_res              r_res, n_res;
    logic              r_out_valid;
    t_res              r_out;

    logic [N_W-1:0]    n_use;
    logic              store_we;
    t_rect             wr_rect;
    t_rect             cur;
    logic signed [EXT_W-1:0] lx, ly, hx, hy, px, py, gx, gy, d;
    logic              hit, last, better, load_out;

    // Clamp the count to the table depth
    always_comb begin
        if (32'(r_rect_count) > MAX_RECTS) begin
            n_use = N_W'(MAX_RECTS);
        end else begin
            n_use = N_W'(r_rect_count);
        end
    end

    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign store_we = o_q_pop && (i_q_cmd.op == OP_WRITE) && (32'(i_q_cmd.slot) < MAX_RECTS);

    always_comb begin
        wr_rect.left   = i_q_cmd.left;
        wr_rect.top    = i_q_cmd.top;
        wr_rect.width  = (i_q_cmd.width == '0) ? SIZE_W'(1) : i_q_cmd.width;
        wr_rect.height = (i_q_cmd.height == '0) ? SIZE_W'(1) : i_q_cmd.height;
    end

    // Geometry of the entry under scan
    always_comb begin
        cur = r_store[r_idx];
        lx  = sext_coord(cur.left);
        ly  = sext_coord(cur.top);
        hx  = lx + zext_size(cur.width) - ONE_E;
        hy  = ly + zext_size(cur.height) - ONE_E;
        px  = sext_coord(r_cmd.px);
        py  = sext_coord(r_cmd.py);
        if (r_cmd.op == OP_STRICT) begin
            hit = (px > lx) && (px < hx) && (py > ly) && (py < hy);
        end else begin
            hit = (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
        end
        if (px < lx) begin
            gx = lx - px;
        end else if (px > hx) begin
            gx = px - hx;
        end else begin
            gx = '0;
        end
        if (py < ly) begin
            gy = ly - py;
        end else if (py > hy) begin
            gy = py - hy;
        end else begin
            gy = '0;
        end
        d      = (gx > gy) ? gx : gy;
        better = r_first || (d < r_best);
        last   = (N_W'(r_idx) == (r_n - N_W'(1)));
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_first = r_first;
        n_best  = r_best;
        n_bidx  = r_bidx;
        n_res   = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_res   = '0;
                    n_state = ST_DONE;
                    if ((i_q_cmd.op == OP_CONTAIN || i_q_cmd.op == OP_STRICT) &&
                        (n_use != '0)) begin
                        n_idx   = IDX_W'(n_use - N_W'(1));
                        n_state = ST_HIT;
                    end
                end
            end
            ST_HIT: begin
                if (hit) begin
                    n_res.found     = 1'b1;
                    n_res.index     = SLOT_W'(r_idx);
                    n_res.contained = 1'b1;
                    n_state         = ST_DONE;
                end else if (r_idx == '0) begin
                    if (r_cmd.op == OP_CONTAIN) begin
                        n_first = 1'b1;
                        n_state = ST_NEAR;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            ST_NEAR: begin
                if (better) begin
                    n_best = d;
                    n_bidx = r_idx;
                end
                n_first = 1'b0;
                if (last) begin
                    n_res.found     = 1'b1;
                    n_res.index     = SLOT_W'(better ? r_idx : r_bidx);
                    n_res.contained = 1'b0;
                    n_res.cheb_dist = better ? d[DIST_W-1:0] : r_best[DIST_W-1:0];
                    n_state         = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[IDX_W'(i_q_cmd.slot)] <= wr_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_n   <= n_use;
        end
        r_idx  <= n_idx;
        r_best <= n_best;
        r_bidx <= n_bidx;
        r_res  <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rect_count <= '0;
            r_first      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            if (i_cfg_we) begin
                r_rect_count <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HIT || r_state == ST_NEAR) |-> (N_W'(r_idx) < r_n))
        else $error("scan index beyond slots in use");

    a_near_only_contain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEAR) |-> (r_cmd.op == OP_CONTAIN))
        else $error("nearest scan entered for a non-containment query");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |->
        (o_res.index == '0 && !o_res.contained && o_res.cheb_dist == '0))
        else $error("not-found result carries nonzero fields");

endmodule

`default_nettype wire

// File: hw/rtl/rect_hit_test_nearest.sv
// Rectangle hit test with nearest fallback: the back end walks the rectangle
// store one slot per cycle and takes the next command from the front-end queue
// only once the previous result beat has been loaded into its output register,
// so a result beat that waits holds the flow. Synchronous active-low reset
// clears the count register and all control state; store contents are undefined.
`default_nettype none

module rect_hit_test_nearest
    import rhtn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration: rect_count
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    // Input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata from bit 0 up: slot[3:0], rect_left[19:4], rect_top[35:20],
    // rect_width[50:36], rect_height[65:51], point_x[81:66], point_y[97:82],
    // zero pad[103:98]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[1:0]
    input  wire logic [KIND_W-1:0]     i_s_axis_tuser,
    // Result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata from bit 0 up: found[0], rect_index[4:1], inside_res[5],
    // distance[22:6], zero pad[23]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    t_res res;

    // Front: decode each beat and park it in the command queue
    rhtn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_kind  (i_s_axis_tuser),
        .i_s_data  (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    // Back: update the store or scan it, then hold the result beat until taken
    rhtn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    // Pack the result beat, lowest field first
    assign o_m_axis_tdata = {1'b0, res.cheb_dist, res.contained, res.index, res.found};

endmodule

`default_nettype wire

// File: bench/rect_hit_test_nearest_tb.sv
// Self-checking bench for rect_hit_test_nearest: loads rectangles, sweeps the count
// register and checks every result beat against an in-bench predictor.
// Depends on rhtn_pkg and the rect_hit_test_nearest RTL only.
`default_nettype none

module rect_hit_test_nearest_tb;
    import rhtn_pkg::*;

    // Kind code that the block must ignore (answers with all-zero fields)
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 250;
    localparam int HOLD_AT      = 300;   // accepted beats before the long sink hold
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 2 * MAX_RECTS + 8;

    // One request beat, fields as they travel on the input stream
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic [IN_COORD_W-1:0] left;
        logic [IN_COORD_W-1:0] top;
        logic [SIZE_W-1:0]     width;
        logic [SIZE_W-1:0]     height;
        logic [IN_COORD_W-1:0] px;
        logic [IN_COORD_W-1:0] py;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    // One answer beat
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
        logic              contained;
        logic [DIST_W-1:0] cheb_dist;
    } hit_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]    s_tuser   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    always #5 clk = ~clk;

    rect_hit_test_nearest dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the rectangle table and the count
    // ------------------------------------------------------------------
    int rect_left [MAX_RECTS];
    int rect_top  [MAX_RECTS];
    int rect_w    [MAX_RECTS];
    int rect_h    [MAX_RECTS];
    int slots_live = 0;

    req_t req_queue [$];     // beats waiting for the driver
    hit_t hit_queue [$];     // answers owed by the block, oldest first

    req_t drv_req;
    hit_t want_hit;
    int   src_gap = 0;
    int   snk_gap = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   accepted_cnt = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   errors = 0;

    // What the run reached, for the closing summary
    int n_writes = 0, n_inside = 0, n_nearest = 0, n_strict = 0, n_empty = 0;

    // Distance from p to the closed span [lo, lo+len-1]
    function automatic int axis_gap(int p, int lo, int len);
        if (p < lo) return lo - p;
        if (p > lo + len - 1) return p - (lo + len - 1);
        return 0;
    endfunction

    // Apply one accepted beat to the table copy and work out its answer
    function automatic hit_t resolve_request(req_t b);
        hit_t r;
        int   n, px, py, d, best, gx, gy;
        r.found     = 1'b0;
        r.index     = '0;
        r.contained = 1'b0;
        r.cheb_dist = '0;
        n  = (slots_live > MAX_RECTS) ? MAX_RECTS : slots_live;
        px = int'($signed(b.px));
        py = int'($signed(b.py));
        case (b.kind)
            KIND_WRITE: begin
                rect_left[b.slot] = int'($signed(b.left));
                rect_top[b.slot]  = int'($signed(b.top));
                // zero size counts as one cell
                rect_w[b.slot]    = (b.width == '0) ? 1 : int'(b.width);
                rect_h[b.slot]    = (b.height == '0) ? 1 : int'(b.height);
            end
            KIND_CONTAIN: begin
                if (n > 0) begin
                    // highest slot that holds the point wins
                    for (int i = n - 1; i >= 0; i--) begin
                        if (!r.found && px >= rect_left[i] && px < rect_left[i] + rect_w[i] &&
                            py >= rect_top[i] && py < rect_top[i] + rect_h[i]) begin
                            r.found     = 1'b1;
                            r.index     = SLOT_W'(i);
                            r.contained = 1'b1;
                        end
                    end
                    // otherwise the lowest slot at the smallest Chebyshev distance
                    if (!r.found) begin
                        best = -1;
                        for (int i = 0; i < n; i++) begin
                            gx = axis_gap(px, rect_left[i], rect_w[i]);
                            gy = axis_gap(py, rect_top[i], rect_h[i]);
                            d  = (gx > gy) ? gx : gy;
                            if (best < 0 || d < best) begin
                                best    = d;
                                r.index = SLOT_W'(i);
                            end
                        end
                        r.found     = 1'b1;
                        r.cheb_dist = DIST_W'(best);
                    end
                end
            end
            KIND_STRICT: begin
                // interior only, border ring excluded; no fallback
                for (int i = n - 1; i >= 0; i--) begin
                    if (!r.found && px > rect_left[i] && px < rect_left[i] + rect_w[i] - 1 &&
                        py > rect_top[i] && py < rect_top[i] + rect_h[i] - 1) begin
                        r.found     = 1'b1;
                        r.index     = SLOT_W'(i);
                        r.contained = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_write(input int slot, input int l, input int t, input int w,
                              input int h);
        req_t b;
        b.kind   = KIND_WRITE;
        b.slot   = SLOT_W'(slot);
        b.left   = IN_COORD_W'(l);
        b.top    = IN_COORD_W'(t);
        b.width  = SIZE_W'(w);
        b.height = SIZE_W'(h);
        b.px     = IN_COORD_W'($urandom);
        b.py     = IN_COORD_W'($urandom);
        req_queue.insert(req_queue.size(), b);
    endtask

    task automatic push_query(input logic [KIND_W-1:0] kind, input int x, input int y);
        req_t b;
        b        = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
        b.kind   = kind;
        b.px     = IN_COORD_W'(x);
        b.py     = IN_COORD_W'(y);
        req_queue.insert(req_queue.size(), b);
    endtask

    // Mostly clustered rectangles and points so that hits, strict hits and
    // near misses all come up; the rest spans the full field ranges.
    function automatic req_t random_request();
        req_t b;
        int   pick;
        b    = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 25)      b.kind = KIND_WRITE;
        else if (pick < 62) b.kind = KIND_CONTAIN;
        else if (pick < 95) b.kind = KIND_STRICT;
        else                b.kind = KIND_UNUSED;
        if ($urandom_range(0, 99) < 85) begin
            b.left   = IN_COORD_W'($urandom_range(0, 80) - 40);
            b.top    = IN_COORD_W'($urandom_range(0, 80) - 40);
            b.width  = SIZE_W'($urandom_range(1, 24));
            b.height = SIZE_W'($urandom_range(1, 24));
        end
        if ($urandom_range(0, 99) < 85) begin
            b.px = IN_COORD_W'($urandom_range(0, 120) - 60);
            b.py = IN_COORD_W'($urandom_range(0, 120) - 60);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued beats, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid      <= 1'b0;
            accepted_cnt <= 0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                want_hit = resolve_request(drv_req);
                hit_queue.insert(hit_queue.size(), want_hit);
                accepted_cnt <= accepted_cnt + 1;
                case (drv_req.kind)
                    KIND_WRITE: n_writes++;
                    KIND_CONTAIN: if (want_hit.contained) n_inside++;
                                  else if (want_hit.found) n_nearest++;
                                  else n_empty++;
                    KIND_STRICT: if (want_hit.found) n_strict++; else n_empty++;
                    default: ;
                endcase
            end
            // advance only when the current beat has gone or none is up
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    drv_req = req_queue.pop_front();
                    s_tdata <= {6'b0, drv_req.py, drv_req.px, drv_req.height, drv_req.width,
                                drv_req.top, drv_req.left, drv_req.slot};
                    s_tuser <= drv_req.kind;
                    s_valid <= 1'b1;
                    // idle burst after this beat goes through
                    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off: once, well into the run, stop draining
    // results so the block backs up and drops its input ready
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take result beats, compare with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (hit_queue.size() == 0) begin
                    $error("result beat %h with no request outstanding", m_tdata);
                    errors++;
                end else begin
                    want_hit = hit_queue.pop_front();
                    if (m_tdata[0] !== want_hit.found) begin
                        $error("found: expected %0d, got %0d", want_hit.found, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[4:1] !== want_hit.index) begin
                        $error("rect_index: expected %0d, got %0d", want_hit.index, m_tdata[4:1]);
                        errors++;
                    end
                    if (m_tdata[5] !== want_hit.contained) begin
                        $error("inside_res: expected %0d, got %0d", want_hit.contained,
                               m_tdata[5]);
                        errors++;
                    end
                    if (m_tdata[22:6] !== want_hit.cheb_dist) begin
                        $error("distance: expected %0d, got %0d", want_hit.cheb_dist,
                               m_tdata[22:6]);
                        errors++;
                    end
                end
            end
            // back-pressure: long hold first, then random stall bursts
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_gap = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    // Wait until every queued beat went in and every answer came back
    task automatic drain();
        do @(negedge clk);
        while (req_queue.size() != 0 || s_valid || hit_queue.size() != 0);
    endtask

    // Write the count register while the block is idle
    task automatic program_count(input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        slots_live = value;
    endtask

    initial begin
        int cnt;
        for (int i = 0; i < MAX_RECTS; i++) begin
            rect_left[i] = 0;
            rect_top[i]  = 0;
            rect_w[i]    = 1;
            rect_h[i]    = 1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table (count still zero from reset), the unused kind, then
        // fill every slot before any query can read one
        @(negedge clk);
        push_query(KIND_CONTAIN, -32768, 32767);
        push_query(KIND_STRICT, 32767, -32768);
        req_queue.insert(req_queue.size(), '1);   // unused kind, all fields ones
        push_write(0, -32768, -32768, 32767, 32767);
        push_write(1, 32767, 32767, 1, 1);
        push_write(2, 0, 0, 0, 0);                // zero size acts as 1x1
        push_write(3, 100, 100, 3, 3);            // single interior cell
        push_write(4, 100, 100, 2, 2);            // no interior at all
        for (int s = 5; s < MAX_RECTS; s++)
            push_write(s, 1000 + 64 * s, 1000 + 64 * s, $urandom_range(1, 30),
                       $urandom_range(1, 30));
        drain();

        // Full table: overlap order, strict interior, border miss, far
        // points, and a distance tie that the lower slot must win
        program_count(MAX_RECTS);
        @(negedge clk);
        push_query(KIND_CONTAIN, 101, 101);
        push_query(KIND_STRICT, 101, 101);
        push_query(KIND_STRICT, 100, 100);
        push_query(KIND_CONTAIN, -5, -5);
        push_query(KIND_CONTAIN, 50, 50);
        push_query(KIND_CONTAIN, -32768, 32767);
        push_query(KIND_CONTAIN, 32767, -32768);
        drain();

        // Random phases over a sweep of count settings, extremes included
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cnt = (1 << CFG_W) - 1;      // above the table size
                1:       cnt = 1;
                2:       cnt = MAX_RECTS;
                3:       cnt = MAX_RECTS + 1;
                4:       cnt = 0;
                5:       cnt = $urandom_range(2, MAX_RECTS - 1);
                6:       cnt = $urandom_range(0, (1 << CFG_W) - 1);
                default: cnt = MAX_RECTS;
            endcase
            program_count(cnt);
            @(negedge clk);
            // no idling in the fourth phase and in the final one
            src_idle_pct = (ph == 3 || ph == PHASES - 1) ? 0 : $urandom_range(5, 40);
            snk_idle_pct = (ph == 3 || ph == PHASES - 1) ? 0 : $urandom_range(5, 40);
            for (int k = 0; k < PHASE_BEATS; k++)
                req_queue.insert(req_queue.size(), random_request());
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (hit_queue.size() != 0) begin
            $error("%0d answers never arrived", hit_queue.size());
            errors++;
        end
        $display("covered %0d request beats: %0d writes, %0d containment hits, %0d nearest picks,",
                 accepted_cnt, n_writes, n_inside, n_nearest);
        $display("  %0d strict interior hits, %0d not-found answers, %0d mismatches",
                 n_strict, n_empty, errors);
        if (errors == 0) begin
            $display("[rect_hit_test_nearest] OK");
        end else begin
            $display("[rect_hit_test_nearest] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[rect_hit_test_nearest] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
